### src/vgam_pkg.sv
// Shared widths, codes and item types of the voxel grid address mapper.
package vgam_pkg;

  localparam int unsigned CNT_W     = 11;  // per-axis voxel count, up to 1024
  localparam int unsigned IDX_W     = 10;  // per-axis voxel index
  localparam int unsigned VI_W      = 30;  // linear voxel index
  localparam int unsigned CRD_W     = 32;  // signed Q16.16 coordinate
  localparam int unsigned SZ_W      = 31;  // voxel size
  localparam int unsigned CNTS_W    = 30;  // packed grid counts register
  localparam int unsigned PLANE_W   = 2 * CNT_W;
  localparam int unsigned DIV_Q     = 11;  // quotient bits of every divider
  localparam int unsigned IN_DATA_W = 160;
  localparam int unsigned OUT_DATA_W = 160;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [2:0] FUNC_P2V    = 3'd0;
  localparam logic [2:0] FUNC_IDX    = 3'd1;
  localparam logic [2:0] FUNC_IJK    = 3'd2;
  localparam logic [2:0] FUNC_CORNER = 3'd3;
  localparam logic [2:0] FUNC_INSIDE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS = 3'd6;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_P2V,
    KIND_IDX,
    KIND_IJK,
    KIND_CORNER,
    KIND_INSIDE
  } kind_e;

  // Effective grid: sizes already forced non-zero, counts already capped.
  typedef struct packed {
    logic [2:0][CRD_W-1:0] mn;
    logic [2:0][SZ_W-1:0]  sz;
    logic [2:0][CNT_W-1:0] n;
  } cfg_t;

  typedef struct packed {
    kind_e                 kind;
    logic                  req_ok;
    logic [VI_W-1:0]       vindex;
    logic [2:0][IDX_W-1:0] req;
    logic [2:0]            corner;
    logic [2:0][CRD_W-1:0] p;
  } item_t;

  typedef struct packed {
    logic                  ok;
    logic                  in_voxel;
    logic [2:0][IDX_W-1:0] idx;
    logic [VI_W-1:0]       lin;
    logic [2:0][CRD_W-1:0] co;
  } res_t;

endpackage

### src/voxel_grid_address_mapper_core.sv
// Top level of the voxel grid address mapper: configuration registers and stream ports.
//
// This block maps between points and voxels of a 3D grid in signed Q16.16
// coordinates, one request per item and exactly one result item per request,
// in order. It takes a new item in every clock cycle and keeps that rate for
// as long as the output side accepts results; throughput is one item per
// cycle. The item is taken into the input register at the accepting edge and
// then passes the queue, two set-up stages, two chained pipelined dividers of
// eleven stages each (the linear index is split first by the plane size and
// then by the x count, and the point offsets are divided by the voxel sizes
// alongside the second of them), a multiply stage, a coordinate stage and the
// output register. When the output stalls, the whole arithmetic pipeline
// holds, and the two-entry queue plus the input register soak up items already
// offered. Configuration must be written only while no item is in flight;
// there is no memory and so no clearing pass.
module voxel_grid_address_mapper_core #(
  parameter int MAX_VOXELS_PER_AXIS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // lowest bit up: voxel_index[29:0], req_ix, req_iy, req_iz, corner,
  // point_x, point_y, point_z, one zero pad bit
  input  logic [vgam_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // func
  input  logic [2:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // lowest bit up: inside_res, out_ix, out_iy, out_iz, linear_index,
  // out_x, out_y, out_z, three zero pad bits
  output logic [vgam_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // ok
  output logic                             m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [vgam_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [31:0]                      cfg_wdata_i
);

  import vgam_pkg::*;

  logic [CRD_W-1:0]  min_q  [3];
  logic [SZ_W-1:0]   size_q [3];
  logic [CNTS_W-1:0] counts_q;
  cfg_t              cfg;

  logic  front_vld;
  item_t front_item;
  logic  fifo_full;
  logic  fifo_push;
  logic  fifo_vld;
  item_t fifo_item;
  logic  back_pop;
  res_t  res;

  // Register writes; an index past the list is simply ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        min_q[a]  <= '0;
        size_q[a] <= SZ_W'(65536);
      end
      counts_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_X:  min_q[0]  <= cfg_wdata_i;
        REG_MIN_Y:  min_q[1]  <= cfg_wdata_i;
        REG_MIN_Z:  min_q[2]  <= cfg_wdata_i;
        REG_SIZE_X: size_q[0] <= cfg_wdata_i[SZ_W-1:0];
        REG_SIZE_Y: size_q[1] <= cfg_wdata_i[SZ_W-1:0];
        REG_SIZE_Z: size_q[2] <= cfg_wdata_i[SZ_W-1:0];
        REG_COUNTS: counts_q  <= cfg_wdata_i[CNTS_W-1:0];
        default: ;
      endcase
    end
  end

  // The effective grid: a zero size behaves as the smallest step, and each
  // count is the field plus one, capped at the largest supported count.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cfg.mn[a] = min_q[a];
      cfg.sz[a] = (size_q[a] == '0) ? SZ_W'(1) : size_q[a];
      cfg.n[a]  = CNT_W'(counts_q[a*IDX_W +: IDX_W]) + CNT_W'(1);
      if (int'(cfg.n[a]) > MAX_VOXELS_PER_AXIS) begin
        cfg.n[a] = CNT_W'(MAX_VOXELS_PER_AXIS);
      end
    end
  end

  vgam_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_func_i  (s_axis_tuser),
    .cfg_i      (cfg),
    .item_vld_o (front_vld),
    .item_o     (front_item),
    .item_rdy_i (!fifo_full)
  );

  assign fifo_push = front_vld && !fifo_full;

  vgam_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (front_item),
    .full_o      (fifo_full),
    .pop_i       (back_pop),
    .vld_o       (fifo_vld),
    .pop_data_o  (fifo_item)
  );

  vgam_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .item_vld_i (fifo_vld),
    .item_i     (fifo_item),
    .item_pop_o (back_pop),
    .res_vld_o  (m_axis_tvalid),
    .res_o      (res),
    .res_rdy_i  (m_axis_tready)
  );

  assign m_axis_tdata = {3'b000, res.co, res.lin, res.idx, res.in_voxel};
  assign m_axis_tuser = res.ok;

endmodule

### src/vgam_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module vgam_div #(
  parameter int unsigned NUM_W = 33,
  parameter int unsigned DEN_W = 31,
  parameter int unsigned Q_W   = 11
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o,
  output logic [NUM_W-1:0] rem_o
);

  localparam int unsigned W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

  logic [NUM_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W-1];

  // The numerator must stay below den * 2**Q_W for the quotient to be exact.
  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int unsigned K = Q_W - 1 - j;
    logic [NUM_W-1:0] rem_in;
    logic [Q_W-1:0]   quo_in;
    logic [DEN_W-1:0] den_in;
    logic [W-1:0]     dsh;
    logic [W-1:0]     diff;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
    end

    assign dsh  = W'(den_in) << K;
    assign diff = W'(rem_in) - dsh;
    assign ge   = W'(rem_in) >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? diff[NUM_W-1:0] : rem_in;
        quo_q[j] <= {quo_in[Q_W-2:0], ge};
      end
    end

    if (j < Q_W - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[j] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];
  assign rem_o = rem_q[Q_W-1];

endmodule

### src/vgam_front.sv
// Front end: accepts items, decodes the mode and checks requested axis indices.
module vgam_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [vgam_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic [2:0]                     in_func_i,
  input  vgam_pkg::cfg_t                 cfg_i,
  output logic                           item_vld_o,
  output vgam_pkg::item_t                item_o,
  input  logic                           item_rdy_i
);

  import vgam_pkg::*;

  logic  vld_q;
  item_t item_q;
  item_t item_d;
  logic  accept;

  always_comb begin
    item_d        = '0;
    item_d.vindex = in_data_i[29:0];
    item_d.req    = in_data_i[59:30];
    item_d.corner = in_data_i[62:60];
    item_d.p      = in_data_i[158:63];
    case (in_func_i)
      FUNC_P2V:    item_d.kind = KIND_P2V;
      FUNC_IDX:    item_d.kind = KIND_IDX;
      FUNC_IJK:    item_d.kind = KIND_IJK;
      FUNC_CORNER: item_d.kind = KIND_CORNER;
      FUNC_INSIDE: item_d.kind = KIND_INSIDE;
      default:     item_d.kind = KIND_NONE;
    endcase
    item_d.req_ok = ({1'b0, item_d.req[0]} < cfg_i.n[0]) &&
                    ({1'b0, item_d.req[1]} < cfg_i.n[1]) &&
                    ({1'b0, item_d.req[2]} < cfg_i.n[2]);
  end

  assign in_ready_o = !vld_q || item_rdy_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (item_rdy_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule

### src/vgam_fifo.sv
// Two-entry queue that decouples the front end from the arithmetic back end.
module vgam_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vgam_pkg::item_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            vld_o,
  output vgam_pkg::item_t pop_data_o
);

  import vgam_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o     = cnt_q == 2'd2;
  assign vld_o      = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

endmodule

### src/vgam_back.sv
// Back end: pipelined bounds checks, index division, coordinate arithmetic.
module vgam_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vgam_pkg::cfg_t  cfg_i,
  input  logic            item_vld_i,
  input  vgam_pkg::item_t item_i,
  output logic            item_pop_o,
  output logic            res_vld_o,
  output vgam_pkg::res_t  res_o,
  input  logic            res_rdy_i
);

  import vgam_pkg::*;

  localparam int unsigned DIFF_W = CRD_W + 1;
  localparam int unsigned NSZ_W  = CNT_W + SZ_W;
  localparam int unsigned TOT_W  = PLANE_W + CNT_W;
  localparam int unsigned BASE_W = NSZ_W + 2;

  typedef struct packed {
    kind_e                  kind;
    logic                   ok;
    logic [2:0]             corner;
    logic [2:0][CRD_W-1:0]  p;
    logic [2:0][DIFF_W-1:0] d;
    logic [2:0][IDX_W-1:0]  req;
    logic [PLANE_W-1:0]     plane;
    logic [CNT_W-1:0]       iz;
  } sb_t;

  logic en;
  logic pop;

  // Stage 0: plane size, grid extent per axis, offset from the lower edge
  logic                   s0_vld_q;
  item_t                  s0_item_q;
  logic [PLANE_W-1:0]     s0_plane_q;
  logic [2:0][NSZ_W-1:0]  s0_nsz_q;
  logic [2:0][DIFF_W-1:0] s0_d_q;
  logic [PLANE_W-1:0]     s0_plane_d;
  logic [2:0][NSZ_W-1:0]  s0_nsz_d;
  logic [2:0][DIFF_W-1:0] s0_d_d;

  // Stage 1: total voxel count and validity
  logic            s1_vld_q;
  sb_t             s1_sb_q;
  logic [VI_W-1:0] s1_vi_q;
  sb_t             s1_sb_d;
  logic [TOT_W-1:0] total;
  logic            inb;

  // Division lines
  logic [DIV_Q-1:0] a_vld_q;
  logic [DIV_Q-1:0] b_vld_q;
  sb_t              sb_a_q [DIV_Q];
  sb_t              sb_b_q [DIV_Q];
  sb_t              sb_a_out;
  sb_t              sb_b;
  logic [DIV_Q-1:0] z_quo;
  logic [VI_W-1:0]  z_rem;
  logic [DIV_Q-1:0] y_quo;
  logic [VI_W-1:0]  y_rem;
  logic [2:0][DIV_Q-1:0] p_quo;

  // Multiply stage
  logic                  sm_vld_q;
  kind_e                 sm_kind_q;
  logic                  sm_ok_q;
  logic [2:0]            sm_corner_q;
  logic [2:0][CRD_W-1:0] sm_p_q;
  logic [2:0][CNT_W-1:0] sm_idx_q;
  logic [2:0][NSZ_W-1:0] sm_prod_q;
  logic [VI_W-1:0]       sm_lz_q;
  logic [PLANE_W-1:0]    sm_ly_q;
  logic                  sm_ok_d;
  logic [2:0][CNT_W-1:0] sm_idx_d;
  logic [2:0][NSZ_W-1:0] sm_prod_d;
  logic [TOT_W-1:0]      sm_lz_full;

  // Base coordinate stage
  logic                   f1_vld_q;
  kind_e                  f1_kind_q;
  logic                   f1_ok_q;
  logic [2:0][CRD_W-1:0]  f1_p_q;
  logic [2:0][CNT_W-1:0]  f1_idx_q;
  logic [2:0][BASE_W-1:0] f1_base_q;
  logic [2:0][SZ_W-1:0]   f1_extra_q;
  logic [VI_W-1:0]        f1_lin_q;
  logic [2:0][BASE_W-1:0] f1_base_d;
  logic [2:0][SZ_W-1:0]   f1_extra_d;

  // Output register
  logic out_vld_q;
  res_t res_q;
  res_t res_d;

  assign en         = !out_vld_q || res_rdy_i;
  assign pop        = en && item_vld_i;
  assign item_pop_o = pop;

  always_comb begin
    s0_plane_d = PLANE_W'(cfg_i.n[0]) * PLANE_W'(cfg_i.n[1]);
    for (int a = 0; a < 3; a++) begin
      s0_nsz_d[a] = NSZ_W'(cfg_i.n[a]) * NSZ_W'(cfg_i.sz[a]);
      s0_d_d[a]   = {item_i.p[a][CRD_W-1], item_i.p[a]} -
                    {cfg_i.mn[a][CRD_W-1], cfg_i.mn[a]};
    end
  end

  always_comb begin
    total = TOT_W'(s0_plane_q) * TOT_W'(cfg_i.n[2]);
    inb   = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (s0_d_q[a][DIFF_W-1] || (NSZ_W'(s0_d_q[a]) > s0_nsz_q[a])) begin
        inb = 1'b0;
      end
    end
    s1_sb_d        = '0;
    s1_sb_d.kind   = s0_item_q.kind;
    s1_sb_d.corner = s0_item_q.corner;
    s1_sb_d.p      = s0_item_q.p;
    s1_sb_d.d      = s0_d_q;
    s1_sb_d.req    = s0_item_q.req;
    s1_sb_d.plane  = s0_plane_q;
    case (s0_item_q.kind)
      KIND_P2V:    s1_sb_d.ok = inb;
      KIND_IJK:    s1_sb_d.ok = s0_item_q.req_ok;
      KIND_IDX,
      KIND_CORNER,
      KIND_INSIDE: s1_sb_d.ok = TOT_W'(s0_item_q.vindex) < total;
      default:     s1_sb_d.ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_item_q  <= item_i;
      s0_plane_q <= s0_plane_d;
      s0_nsz_q   <= s0_nsz_d;
      s0_d_q     <= s0_d_d;
      s1_sb_q    <= s1_sb_d;
      s1_vi_q    <= s0_item_q.vindex;
    end
  end

  // z index first: vindex over the plane size
  vgam_div #(.NUM_W(VI_W), .DEN_W(PLANE_W), .Q_W(DIV_Q)) u_div_z (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s1_vi_q),
    .den_i (s1_sb_q.plane),
    .quo_o (z_quo),
    .rem_o (z_rem)
  );

  always_comb begin
    sb_a_out    = sb_a_q[DIV_Q-1];
    sb_a_out.iz = z_quo;
  end

  // then y and x from the remainder within the plane
  vgam_div #(.NUM_W(VI_W), .DEN_W(CNT_W), .Q_W(DIV_Q)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (z_rem),
    .den_i (cfg_i.n[0]),
    .quo_o (y_quo),
    .rem_o (y_rem)
  );

  for (genvar a = 0; a < 3; a++) begin : g_pdiv
    vgam_div #(.NUM_W(DIFF_W), .DEN_W(SZ_W), .Q_W(DIV_Q)) u_div_p (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (sb_a_q[DIV_Q-1].d[a]),
      .den_i (cfg_i.sz[a]),
      .quo_o (p_quo[a]),
      .rem_o ()
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_a_q[0] <= s1_sb_q;
      sb_b_q[0] <= sb_a_out;
      for (int i = 1; i < DIV_Q; i++) begin
        sb_a_q[i] <= sb_a_q[i-1];
        sb_b_q[i] <= sb_b_q[i-1];
      end
    end
  end

  assign sb_b = sb_b_q[DIV_Q-1];

  always_comb begin
    sm_ok_d  = sb_b.ok;
    sm_idx_d = '0;
    case (sb_b.kind)
      KIND_P2V: begin
        for (int a = 0; a < 3; a++) begin
          // a point on the upper edge falls into the last voxel
          sm_idx_d[a] = (p_quo[a] >= cfg_i.n[a]) ? cfg_i.n[a] - CNT_W'(1) : p_quo[a];
        end
      end
      KIND_IJK: begin
        for (int a = 0; a < 3; a++) begin
          sm_idx_d[a] = {1'b0, sb_b.req[a]};
        end
      end
      KIND_IDX, KIND_CORNER, KIND_INSIDE: begin
        sm_idx_d[0] = y_rem[CNT_W-1:0];
        sm_idx_d[1] = y_quo;
        sm_idx_d[2] = sb_b.iz;
      end
      default: sm_ok_d = 1'b0;
    endcase
    for (int a = 0; a < 3; a++) begin
      sm_prod_d[a] = NSZ_W'(sm_idx_d[a]) * NSZ_W'(cfg_i.sz[a]);
    end
    sm_lz_full = TOT_W'(sm_idx_d[2]) * TOT_W'(sb_b.plane);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sm_kind_q   <= sb_b.kind;
      sm_ok_q     <= sm_ok_d;
      sm_corner_q <= sb_b.corner;
      sm_p_q      <= sb_b.p;
      sm_idx_q    <= sm_idx_d;
      sm_prod_q   <= sm_prod_d;
      sm_lz_q     <= sm_lz_full[VI_W-1:0];
      sm_ly_q     <= PLANE_W'(sm_idx_d[1]) * PLANE_W'(cfg_i.n[0]);
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      f1_base_d[a] = {{(BASE_W-CRD_W){cfg_i.mn[a][CRD_W-1]}}, cfg_i.mn[a]} +
                     BASE_W'(sm_prod_q[a]);
      case (sm_kind_q)
        KIND_IDX, KIND_IJK: f1_extra_d[a] = {1'b0, cfg_i.sz[a][SZ_W-1:1]};
        KIND_CORNER:        f1_extra_d[a] = sm_corner_q[a] ? cfg_i.sz[a] : '0;
        default:            f1_extra_d[a] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_kind_q  <= sm_kind_q;
      f1_ok_q    <= sm_ok_q;
      f1_p_q     <= sm_p_q;
      f1_idx_q   <= sm_idx_q;
      f1_base_q  <= f1_base_d;
      f1_extra_q <= f1_extra_d;
      f1_lin_q   <= sm_lz_q + VI_W'(sm_ly_q) + VI_W'(sm_idx_q[0]);
    end
  end

  always_comb begin
    logic [BASE_W-1:0] co;
    logic [BASE_W-1:0] hi;
    logic [BASE_W-1:0] pe;
    logic              in_box;
    logic              coords;
    res_d  = '0;
    in_box = 1'b1;
    coords = (f1_kind_q == KIND_IDX) || (f1_kind_q == KIND_IJK) ||
             (f1_kind_q == KIND_CORNER);
    for (int a = 0; a < 3; a++) begin
      co = f1_base_q[a] + BASE_W'(f1_extra_q[a]);
      hi = f1_base_q[a] + BASE_W'(cfg_i.sz[a]);
      pe = {{(BASE_W-CRD_W){f1_p_q[a][CRD_W-1]}}, f1_p_q[a]};
      if (($signed(pe) < $signed(f1_base_q[a])) || ($signed(pe) > $signed(hi))) begin
        in_box = 1'b0;
      end
      res_d.idx[a] = f1_idx_q[a][IDX_W-1:0];
      if (!coords) begin
        res_d.co[a] = '0;
      end else if (!co[BASE_W-1] && (|co[BASE_W-2:CRD_W-1])) begin
        res_d.co[a] = {1'b0, {(CRD_W-1){1'b1}}};
      end else if (co[BASE_W-1] && !(&co[BASE_W-2:CRD_W-1])) begin
        res_d.co[a] = {1'b1, {(CRD_W-1){1'b0}}};
      end else begin
        res_d.co[a] = co[CRD_W-1:0];
      end
    end
    res_d.ok       = 1'b1;
    res_d.in_voxel = (f1_kind_q == KIND_INSIDE) && in_box;
    res_d.lin      = f1_lin_q;
    if (!f1_ok_q) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      a_vld_q   <= '0;
      b_vld_q   <= '0;
      sm_vld_q  <= 1'b0;
      f1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q  <= pop;
      s1_vld_q  <= s0_vld_q;
      a_vld_q   <= {a_vld_q[DIV_Q-2:0], s1_vld_q};
      b_vld_q   <= {b_vld_q[DIV_Q-2:0], a_vld_q[DIV_Q-1]};
      sm_vld_q  <= b_vld_q[DIV_Q-1];
      f1_vld_q  <= sm_vld_q;
      out_vld_q <= f1_vld_q;
    end
  end

  assign res_vld_o = out_vld_q;
  assign res_o     = res_q;

endmodule

### verif/voxel_grid_address_mapper_core_tb.sv
// Self-checking testbench for the voxel grid address mapper core.
module voxel_grid_address_mapper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vgam_pkg::*;

  // One request as the sender sees it, fields at the block's own widths.
  typedef struct {
    logic [2:0]        func;
    logic [VI_W-1:0]   vindex;
    logic [IDX_W-1:0]  rx, ry, rz;
    logic [2:0]        corner;
    logic [CRD_W-1:0]  px, py, pz;
  } request_t;

  // One mapping result, in the order the output port carries it.
  typedef struct {
    logic              ok;
    logic              in_voxel;
    logic [IDX_W-1:0]  ix, iy, iz;
    logic [VI_W-1:0]   lin;
    logic [CRD_W-1:0]  x, y, z;
  } mapping_t;

  // Drain time for the pipeline after the last result, with some margin.
  localparam int DRAIN_CYCLES = 40;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [2:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [31:0]           cfg_wdata_i = '0;

  voxel_grid_address_mapper_core DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The testbench's own copy of the grid registers.
  logic signed [31:0] grid_min [3];
  logic [30:0]        grid_size [3];
  logic [29:0]        grid_counts;

  request_t pending_requests [$];
  mapping_t expected_mappings [$];
  int       error_count = 0;

  // Receiver control: a forced long hold-off and a stall pattern.
  int  hold_off_cycles = 0;
  bit  sender_paused = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  logic [7:0] stall_pattern = 8'b1011_0110;
  int  stall_phase = 0;
  bit  stall_enabled = 1'b1;

  function automatic logic [31:0] saturate(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Works out the mapping of one request against the current grid.
  function automatic mapping_t map_request(request_t r);
    mapping_t m;
    longint mn [3], sz [3], cnt [3], pt [3], idx [3], co [3];
    longint total, plane, rest, hi, lo;
    bit ok, in_box, coords;
    m = '{default: '0};
    ok = 1'b0;
    in_box = 1'b0;
    coords = 1'b0;
    for (int a = 0; a < 3; a++) begin
      mn[a] = longint'(grid_min[a]);
      sz[a] = (grid_size[a] == 0) ? 1 : longint'(grid_size[a]);
      cnt[a] = longint'(grid_counts[a*10 +: 10]) + 1;
      if (cnt[a] > 1024) cnt[a] = 1024;
      idx[a] = 0;
      co[a] = 0;
    end
    pt[0] = longint'($signed(r.px));
    pt[1] = longint'($signed(r.py));
    pt[2] = longint'($signed(r.pz));
    total = cnt[0] * cnt[1] * cnt[2];
    if (r.func == FUNC_P2V) begin
      ok = 1'b1;
      for (int a = 0; a < 3; a++) begin
        hi = mn[a] + cnt[a] * sz[a];
        if (pt[a] < mn[a] || pt[a] > hi) ok = 1'b0;
      end
      if (ok) begin
        // Offsets are non-negative here, so truncation is the floor.
        for (int a = 0; a < 3; a++) begin
          idx[a] = (pt[a] - mn[a]) / sz[a];
          if (idx[a] >= cnt[a]) idx[a] = cnt[a] - 1;
        end
      end
    end else if (r.func == FUNC_IJK) begin
      ok = 1'b1;
      idx[0] = r.rx;
      idx[1] = r.ry;
      idx[2] = r.rz;
      for (int a = 0; a < 3; a++)
        if (idx[a] >= cnt[a]) ok = 1'b0;
    end else if (r.func == FUNC_IDX || r.func == FUNC_CORNER || r.func == FUNC_INSIDE) begin
      if (longint'(r.vindex) < total) begin
        ok = 1'b1;
        plane = cnt[0] * cnt[1];
        rest = longint'(r.vindex) % plane;
        idx[2] = longint'(r.vindex) / plane;
        idx[1] = rest / cnt[0];
        idx[0] = rest % cnt[0];
      end
    end
    if (!ok) return m;
    if (r.func == FUNC_IDX || r.func == FUNC_IJK) begin
      coords = 1'b1;
      for (int a = 0; a < 3; a++) co[a] = mn[a] + idx[a] * sz[a] + (sz[a] >>> 1);
    end else if (r.func == FUNC_CORNER) begin
      coords = 1'b1;
      for (int a = 0; a < 3; a++) co[a] = mn[a] + (idx[a] + r.corner[a]) * sz[a];
    end else if (r.func == FUNC_INSIDE) begin
      in_box = 1'b1;
      for (int a = 0; a < 3; a++) begin
        lo = mn[a] + idx[a] * sz[a];
        if (pt[a] < lo || pt[a] > lo + sz[a]) in_box = 1'b0;
      end
    end
    m.ok = 1'b1;
    m.in_voxel = in_box;
    m.ix = idx[0][9:0];
    m.iy = idx[1][9:0];
    m.iz = idx[2][9:0];
    m.lin = 30'(idx[2] * cnt[0] * cnt[1] + idx[1] * cnt[0] + idx[0]);
    if (coords) begin
      m.x = saturate(co[0]);
      m.y = saturate(co[1]);
      m.z = saturate(co[2]);
    end
    return m;
  endfunction

  // Driver: the sender offers items in bursts with random gaps between them.
  always @(posedge clk_i) begin
    request_t r;
    if (s_axis_tvalid && s_axis_tready) begin
      expected_mappings.push_back(map_request(pending_requests.pop_front()));
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (burst_left == 0 && gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 40);
        if ($urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 12);
      end
      // The queue head moves on only after the pop above.
      if (pending_requests.size() > 0 && !sender_paused && burst_left > 0) begin
        r = pending_requests[0];
        s_axis_tdata <= {1'b0, r.pz, r.py, r.px, r.corner, r.rz, r.ry, r.rx, r.vindex};
        s_axis_tuser <= r.func;
        s_axis_tvalid <= 1'b1;
        burst_left <= burst_left - 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor and stall pattern: each accepted result is checked against the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    mapping_t e, got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.ok = m_axis_tuser;
      got.in_voxel = m_axis_tdata[0];
      got.ix = m_axis_tdata[10:1];
      got.iy = m_axis_tdata[20:11];
      got.iz = m_axis_tdata[30:21];
      got.lin = m_axis_tdata[60:31];
      got.x = m_axis_tdata[92:61];
      got.y = m_axis_tdata[124:93];
      got.z = m_axis_tdata[156:125];
      if (expected_mappings.size() == 0) begin
        $display("%0t: unexpected result ok=%0b lin=%0d", $time, got.ok, got.lin);
        error_count++;
      end else begin
        e = expected_mappings.pop_front();
        if (got.ok !== e.ok) begin
          $display("%0t: ok expected %0b actual %0b", $time, e.ok, got.ok);
          error_count++;
        end
        if (got.in_voxel !== e.in_voxel) begin
          $display("%0t: inside expected %0b actual %0b", $time, e.in_voxel, got.in_voxel);
          error_count++;
        end
        if ({got.ix, got.iy, got.iz} !== {e.ix, e.iy, e.iz}) begin
          $display("%0t: indices expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
                   e.ix, e.iy, e.iz, got.ix, got.iy, got.iz);
          error_count++;
        end
        if (got.lin !== e.lin) begin
          $display("%0t: linear index expected %0d actual %0d", $time, e.lin, got.lin);
          error_count++;
        end
        if ({got.x, got.y, got.z} !== {e.x, e.y, e.z}) begin
          $display("%0t: coords expected %h/%h/%h actual %h/%h/%h", $time,
                   e.x, e.y, e.z, got.x, got.y, got.z);
          error_count++;
        end
      end
    end
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 8;
      m_axis_tready <= !stall_enabled || stall_pattern[stall_phase] || ($urandom_range(0, 3) == 0);
      if (stall_phase == 7 && $urandom_range(0, 9) == 0) stall_pattern <= 8'($urandom);
      if (stall_phase == 7 && $urandom_range(0, 19) == 0) stall_enabled <= !stall_enabled;
    end
  end

  // Writes one register both into the block and into the testbench's copy.
  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (index)
      REG_MIN_X:  grid_min[0] = value;
      REG_MIN_Y:  grid_min[1] = value;
      REG_MIN_Z:  grid_min[2] = value;
      REG_SIZE_X: grid_size[0] = value[30:0];
      REG_SIZE_Y: grid_size[1] = value[30:0];
      REG_SIZE_Z: grid_size[2] = value[30:0];
      REG_COUNTS: grid_counts = value[29:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [31:0] mx, my, mz, sx, sy, sz, counts);
    write_register(REG_MIN_X, mx);
    write_register(REG_MIN_Y, my);
    write_register(REG_MIN_Z, mz);
    write_register(REG_SIZE_X, sx);
    write_register(REG_SIZE_Y, sy);
    write_register(REG_SIZE_Z, sz);
    write_register(REG_COUNTS, counts);
  endtask

  // Waits until every request is sent and every result is back, then lets the
  // pipeline settle before configuration changes.
  task automatic wait_idle();
    while (pending_requests.size() > 0 || expected_mappings.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Point coordinate on one axis, usually near the grid, sometimes anywhere.
  function automatic logic [31:0] pick_coord(int a);
    longint lo, span;
    lo = longint'(grid_min[a]);
    span = (longint'(grid_counts[a*10 +: 10]) + 1) *
           ((grid_size[a] == 0) ? 1 : longint'(grid_size[a]));
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return saturate(lo);
      2: return saturate(lo + span);
      3: return saturate(lo - 1);
      4: return saturate(lo + span + 1);
      default: return saturate(lo + longint'({$urandom, $urandom} % (span + 1)));
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    longint total;
    total = 1;
    for (int a = 0; a < 3; a++) total *= longint'(grid_counts[a*10 +: 10]) + 1;
    r.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    r.vindex = ($urandom_range(0, 7) == 0) ? 30'($urandom) : 30'({$urandom, $urandom} % (total + 1));
    r.rx = ($urandom_range(0, 5) == 0) ? 10'($urandom) : 10'($urandom_range(0, grid_counts[9:0] + 1));
    r.ry = ($urandom_range(0, 5) == 0) ? 10'($urandom) : 10'($urandom_range(0, grid_counts[19:10] + 1));
    r.rz = ($urandom_range(0, 5) == 0) ? 10'($urandom) : 10'($urandom_range(0, grid_counts[29:20] + 1));
    r.corner = 3'($urandom);
    r.px = pick_coord(0);
    r.py = pick_coord(1);
    r.pz = pick_coord(2);
    return r;
  endfunction

  function automatic request_t make_request(logic [2:0] func, logic [29:0] vindex,
                                            logic [9:0] rx, ry, rz, logic [2:0] corner,
                                            logic [31:0] px, py, pz);
    request_t r;
    r.func = func; r.vindex = vindex; r.rx = rx; r.ry = ry; r.rz = rz;
    r.corner = corner; r.px = px; r.py = py; r.pz = pz;
    return r;
  endfunction

  initial begin
    for (int a = 0; a < 3; a++) begin
      grid_min[a] = 0;
      grid_size[a] = 31'd65536;
    end
    grid_counts = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the 1 x 1 x 1 grid left by reset, then on a full grid.
    pending_requests.push_back(make_request(FUNC_P2V, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_request(FUNC_P2V, 0, 0, 0, 0, 0,
                                            32'h10000, 32'h10000, 32'h10000));
    pending_requests.push_back(make_request(FUNC_P2V, 0, 0, 0, 0, 0, 32'h10001, 0, 0));
    pending_requests.push_back(make_request(FUNC_P2V, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0));
    pending_requests.push_back(make_request(FUNC_IDX, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_request(FUNC_IDX, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_request(FUNC_IJK, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_request(FUNC_IJK, 0, 10'h3FF, 10'h3FF, 10'h3FF, 0, 0, 0, 0));
    pending_requests.push_back(make_request(FUNC_CORNER, 0, 0, 0, 0, 3'd7, 0, 0, 0));
    pending_requests.push_back(make_request(FUNC_INSIDE, 0, 0, 0, 0, 0,
                                            32'h10000, 0, 32'h8000));
    pending_requests.push_back(make_request(3'd5, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_request(3'd7, 30'h3FFF_FFFF, 10'h3FF, 10'h3FF, 10'h3FF,
                                            3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    wait_idle();

    // Largest sizes and counts at the top edge force saturation; size zero acts as one.
    set_grid(32'h7FFF_0000, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h3,
             32'h3FFF_FFFF);
    pending_requests.push_back(make_request(FUNC_IDX, 30'h3FFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_request(FUNC_IDX, 30'h3FFF_FFFE,
                                            0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_request(FUNC_IJK, 0, 10'h3FF, 10'h3FF, 10'h3FF, 0, 0, 0, 0));
    pending_requests.push_back(make_request(FUNC_CORNER, 30'd1023, 0, 0, 0, 3'd7, 0, 0, 0));
    pending_requests.push_back(make_request(FUNC_CORNER, 30'd1048575, 0, 0, 0, 3'd0, 0, 0, 0));
    pending_requests.push_back(make_request(FUNC_INSIDE, 30'd2047, 0, 0, 0, 0,
                                            32'h7FFF_FFFF, 32'h8000_0400, 32'h1));
    pending_requests.push_back(make_request(FUNC_P2V, 0, 0, 0, 0, 0,
                                            32'h7FFF_FFFF, 32'h8000_03FF, 32'd3071));
    pending_requests.push_back(make_request(FUNC_P2V, 0, 0, 0, 0, 0,
                                            32'h7FFF_0000, 32'h8000_0400, 32'd3072));
    pending_requests.push_back(make_request(FUNC_P2V, 0, 0, 0, 0, 0,
                                            32'h7FFE_FFFF, 32'h8000_0000, 32'd0));
    wait_idle();

    // Random phases, each on a new grid; one phase holds the receiver off for long.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: set_grid($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: set_grid($urandom_range(0, 255) - 128, 32'hFFFF_0000, 32'd5,
                    $urandom_range(1, 65536), $urandom_range(0, 3), 32'h7FFF_FFFF,
                    32'({10'($urandom_range(0, 7)), 10'($urandom_range(0, 7)),
                         10'($urandom_range(0, 7))}));
        2: set_grid(32'h8000_0000, 32'h7FFF_FFFF, $urandom, 32'h0000_8000, 32'h1,
                    $urandom_range(1, 1 << 20),
                    32'({10'($urandom_range(0, 3)), 10'h3FF, 10'd1}));
        default: set_grid($urandom, $urandom, $urandom,
                          $urandom_range(1, 1 << 18), $urandom_range(1, 1 << 18),
                          $urandom_range(1, 1 << 18), $urandom);
      endcase
      for (int k = 0; k < 110; k++) pending_requests.push_back(random_request());
      if (phase == 2) begin
        hold_off_cycles = 200;
      end
      if (phase == 5) begin
        // Sender stops until all results are back, then carries on.
        while (pending_requests.size() > 55) @(posedge clk_i);
        sender_paused = 1'b1;
        while (expected_mappings.size() > 0 || s_axis_tvalid) @(posedge clk_i);
        sender_paused = 1'b0;
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
